// ===== hw/rtl/complex_arithmetic_unit_defines.svh =====
// Assertion macros for the complex arithmetic unit.
// Depends on the including module having clk and rst_n (synchronous, active low).
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cau_pkg.sv =====
// Shared types, constants and helper functions of the complex arithmetic unit.
// No dependencies; imported by complex_arithmetic_unit.
package cau_pkg;

  localparam int DATA_W   = 16;
  localparam int FRAC     = 8;
  localparam int ANG_FRAC = 24;
  localparam int ANG_SH   = ANG_FRAC - FRAC;
  // quotient bits produced by the divider, one per pipeline step
  localparam int NSTEP    = DATA_W + FRAC + 1;
  localparam int DQ_SH    = NSTEP - FRAC;
  localparam int SQ_STEPS = 16;
  localparam int CORDIC_STEPS = 24;

  localparam logic signed [27:0] ANG_HALF_PI = 28'sd26353589;
  localparam logic signed [27:0] ANG_PI      = 28'sd52707179;
  localparam logic [11:0] ANG_Q_MAX =
    12'((52707179 + (1 << (ANG_SH - 1))) >> ANG_SH);

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_MAG = 3'd4,
    CMD_ARG = 3'd5,
    CMD_EQ  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SAT   = 2'd1,
    ST_UNDEF = 2'd2
  } status_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } sat_t;

  // Work carried down the iteration pipeline
  typedef struct packed {
    cmd_t               cmd;
    logic signed [16:0] lin_re;
    logic signed [16:0] lin_im;
    logic signed [24:0] mul_re;
    logic signed [24:0] mul_im;
    logic               eq;
    logic               den_zero;
    logic               arg_zero;
    logic [31:0]        den;
    logic               neg_re;
    logic               neg_im;
    logic               ovf_re;
    logic               ovf_im;
    logic [NSTEP-1:0]   nb_re;
    logic [NSTEP-1:0]   nb_im;
    logic [31:0]        r_re;
    logic [31:0]        r_im;
    logic [NSTEP-1:0]   q_re;
    logic [NSTEP-1:0]   q_im;
    logic [31:0]        sq_s;
    logic [31:0]        sq_res;
    logic signed [42:0] cx;
    logic signed [42:0] cy;
    logic signed [27:0] cz;
  } iter_t;

  // atan(2^-i) in units of 2^-24 rad
  function automatic logic signed [27:0] atan_of(input logic [4:0] idx);
    logic signed [27:0] r;
    case (idx)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // Clamp a signed value to the output range
  function automatic sat_t sat_sv(input logic signed [25:0] v);
    localparam logic signed [25:0] VMAX = 26'((1 << (DATA_W - 1)) - 1);
    localparam logic signed [25:0] VMIN = -26'(1 << (DATA_W - 1));
    sat_t r;
    r.sat = 1'b0;
    r.val = v[DATA_W-1:0];
    if (v > VMAX) begin
      r.sat = 1'b1;
      r.val = VMAX[DATA_W-1:0];
    end else if (v < VMIN) begin
      r.sat = 1'b1;
      r.val = VMIN[DATA_W-1:0];
    end
    return r;
  endfunction

  // Clamp a sign-magnitude value to the output range
  function automatic sat_t sat_sm(input logic neg, input logic [25:0] mag, input logic ovf);
    localparam logic [25:0] PMAX = 26'((1 << (DATA_W - 1)) - 1);
    localparam logic [25:0] NMAX = 26'(1 << (DATA_W - 1));
    sat_t r;
    logic [25:0] m;
    m = mag;
    r.sat = 1'b0;
    if (neg && (ovf || mag > NMAX)) begin
      m = NMAX;
      r.sat = 1'b1;
    end else if (!neg && (ovf || mag > PMAX)) begin
      m = PMAX;
      r.sat = 1'b1;
    end
    r.val = neg ? DATA_W'(-m) : m[DATA_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit: fully pipelined add, subtract, multiply, divide,
// magnitude, argument and equality test on Q8.8 complex operands.
// Depends on cau_pkg and complex_arithmetic_unit_defines.svh.
//
// Usage:
//  - Input channel: a transfer happens at a rising edge with start high and
//    busy low. busy is high only while rst_n is low, so after reset the unit
//    takes one item on every clock edge.
//  - Result channel: out_valid strobes for one cycle with out_res_real,
//    out_res_imag, out_is_equal and out_status. The receiver cannot stall;
//    results appear in the order items were taken.
//  - Every command passes through the same registers: input and product
//    registers, sums, operand preparation, 25 iteration stages, a rounding
//    stage and the output register. Throughput is one item per cycle.
//  - The 25 iteration stages set the depth: each stage retires one quotient
//    bit of the restoring divider, and also runs one bit pair of the square
//    root (first 16 stages) and one CORDIC rotation (first 24 stages).
//  - Reset clears every valid bit; items in flight are dropped. There is no
//    other state and no configuration.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_command,
  input  logic signed [DATA_W-1:0] in_a_real,
  input  logic signed [DATA_W-1:0] in_a_imag,
  input  logic signed [DATA_W-1:0] in_b_real,
  input  logic signed [DATA_W-1:0] in_b_imag,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_res_real,
  output logic signed [DATA_W-1:0] out_res_imag,
  output logic                     out_is_equal,
  output logic [1:0]               out_status
);

  logic accept;
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // ---------------- stage 1: operands and products ----------------
  logic                     v1_r;
  cmd_t                     cmd1_r;
  logic signed [DATA_W-1:0] ar1_r, ai1_r, br1_r, bi1_r;
  logic signed [31:0]       p_arbr_r, p_aibi_r, p_arbi_r, p_aibr_r;
  logic signed [31:0]       p_brbr_r, p_bibi_r, p_arar_r, p_aiai_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  // Each multiplier feeds a register directly
  always_ff @(posedge clk) begin
    cmd1_r   <= cmd_t'(in_command);
    ar1_r    <= in_a_real;
    ai1_r    <= in_a_imag;
    br1_r    <= in_b_real;
    bi1_r    <= in_b_imag;
    p_arbr_r <= in_a_real * in_b_real;
    p_aibi_r <= in_a_imag * in_b_imag;
    p_arbi_r <= in_a_real * in_b_imag;
    p_aibr_r <= in_a_imag * in_b_real;
    p_brbr_r <= in_b_real * in_b_real;
    p_bibi_r <= in_b_imag * in_b_imag;
    p_arar_r <= in_a_real * in_a_real;
    p_aiai_r <= in_a_imag * in_a_imag;
  end

  // ---------------- stage 2: sums ----------------
  logic                     v2_r;
  cmd_t                     cmd2_r;
  logic signed [32:0]       mre2_r, mim2_r, nre2_r, nim2_r;
  logic [31:0]              den2_r, sq2_r;
  logic signed [16:0]       lre2_r, lim2_r;
  logic                     eq2_r;
  logic signed [DATA_W-1:0] ar2_r, ai2_r;
  logic signed [16:0]       lre2_nxt, lim2_nxt;

  always_comb begin
    if (cmd1_r == CMD_SUB) begin
      lre2_nxt = 17'(ar1_r) - 17'(br1_r);
      lim2_nxt = 17'(ai1_r) - 17'(bi1_r);
    end else begin
      lre2_nxt = 17'(ar1_r) + 17'(br1_r);
      lim2_nxt = 17'(ai1_r) + 17'(bi1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cmd2_r <= cmd1_r;
    mre2_r <= 33'(p_arbr_r) - 33'(p_aibi_r);
    mim2_r <= 33'(p_arbi_r) + 33'(p_aibr_r);
    nre2_r <= 33'(p_arbr_r) + 33'(p_aibi_r);
    nim2_r <= 33'(p_aibr_r) - 33'(p_arbi_r);
    den2_r <= unsigned'(p_brbr_r) + unsigned'(p_bibi_r);
    sq2_r  <= unsigned'(p_arar_r) + unsigned'(p_aiai_r);
    lre2_r <= lre2_nxt;
    lim2_r <= lim2_nxt;
    eq2_r  <= (ar1_r == br1_r) && (ai1_r == bi1_r);
    ar2_r  <= ar1_r;
    ai2_r  <= ai1_r;
  end

  // ---------------- stage 3: operand preparation ----------------
  iter_t              it_r [0:NSTEP];
  logic [NSTEP:0]     vit_r;
  iter_t              prep_nxt;
  logic [31:0]        nabs_re, nabs_im;
  logic signed [32:0] mr_re, mr_im;
  logic signed [16:0] ai_ext, ay, nar;

  always_comb begin
    nabs_re = 32'(nre2_r[32] ? -nre2_r : nre2_r);
    nabs_im = 32'(nim2_r[32] ? -nim2_r : nim2_r);
    // round half away from zero in a single add
    mr_re   = mre2_r + (mre2_r[32] ? 33'sd127 : 33'sd128);
    mr_im   = mim2_r + (mim2_r[32] ? 33'sd127 : 33'sd128);
    ai_ext  = 17'(ai2_r);
    ay      = ai_ext[16] ? -ai_ext : ai_ext;
    nar     = -17'(ar2_r);

    prep_nxt          = '0;
    prep_nxt.cmd      = cmd2_r;
    prep_nxt.lin_re   = lre2_r;
    prep_nxt.lin_im   = lim2_r;
    prep_nxt.mul_re   = 25'(mr_re >>> FRAC);
    prep_nxt.mul_im   = 25'(mr_im >>> FRAC);
    prep_nxt.eq       = eq2_r;
    prep_nxt.den_zero = (den2_r == '0);
    prep_nxt.arg_zero = (ar2_r == '0) && (ai2_r == '0);
    prep_nxt.den      = den2_r;
    prep_nxt.neg_re   = nre2_r[32];
    prep_nxt.neg_im   = nim2_r[32];
    prep_nxt.ovf_re   = (nabs_re >> DQ_SH) >= den2_r;
    prep_nxt.ovf_im   = (nabs_im >> DQ_SH) >= den2_r;
    prep_nxt.r_re     = nabs_re >> DQ_SH;
    prep_nxt.r_im     = nabs_im >> DQ_SH;
    prep_nxt.nb_re    = {nabs_re[DQ_SH-1:0], {FRAC{1'b0}}};
    prep_nxt.nb_im    = {nabs_im[DQ_SH-1:0], {FRAC{1'b0}}};
    prep_nxt.sq_s     = sq2_r;
    prep_nxt.sq_res   = '0;
    // left half plane: turn by -pi/2 first
    if (ar2_r[DATA_W-1]) begin
      prep_nxt.cx = 43'(ay) <<< ANG_FRAC;
      prep_nxt.cy = 43'(nar) <<< ANG_FRAC;
      prep_nxt.cz = ANG_HALF_PI;
    end else begin
      prep_nxt.cx = 43'(ar2_r) <<< ANG_FRAC;
      prep_nxt.cy = 43'(ay) <<< ANG_FRAC;
      prep_nxt.cz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vit_r[0] <= 1'b0;
    end else begin
      vit_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    it_r[0] <= prep_nxt;
  end

  // ---------------- iteration stages ----------------
  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    iter_t              cur, nxt;
    logic [32:0]        t_re, t_im;
    logic [31:0]        sq_s_n, sq_res_n;
    logic signed [42:0] cx_n, cy_n;
    logic signed [27:0] cz_n;

    assign cur = it_r[k];

    if (k < SQ_STEPS) begin : g_sq
      localparam logic [31:0] SQ_ONE = 32'd1 << (2 * (SQ_STEPS - 1 - k));
      logic [31:0] sq_try;
      logic        sq_take;
      assign sq_try   = cur.sq_res + SQ_ONE;
      assign sq_take  = cur.sq_s >= sq_try;
      assign sq_s_n   = sq_take ? cur.sq_s - sq_try : cur.sq_s;
      assign sq_res_n = sq_take ? (cur.sq_res >> 1) + SQ_ONE : cur.sq_res >> 1;
    end else begin : g_sq_hold
      assign sq_s_n   = cur.sq_s;
      assign sq_res_n = cur.sq_res;
    end

    if (k < CORDIC_STEPS) begin : g_cr
      logic signed [42:0] xs, ys;
      logic               up;
      assign xs   = cur.cx >>> k;
      assign ys   = cur.cy >>> k;
      assign up   = cur.cy > 43'sd0;
      assign cx_n = up ? cur.cx + ys : cur.cx - ys;
      assign cy_n = up ? cur.cy - xs : cur.cy + xs;
      assign cz_n = up ? cur.cz + atan_of(5'(k)) : cur.cz - atan_of(5'(k));
    end else begin : g_cr_hold
      assign cx_n = cur.cx;
      assign cy_n = cur.cy;
      assign cz_n = cur.cz;
    end

    always_comb begin
      nxt  = cur;
      // restoring division: shift in one numerator bit, try subtract
      t_re = {cur.r_re, cur.nb_re[NSTEP-1]};
      t_im = {cur.r_im, cur.nb_im[NSTEP-1]};
      if (t_re >= {1'b0, cur.den}) begin
        nxt.r_re = 32'(t_re - {1'b0, cur.den});
        nxt.q_re = {cur.q_re[NSTEP-2:0], 1'b1};
      end else begin
        nxt.r_re = t_re[31:0];
        nxt.q_re = {cur.q_re[NSTEP-2:0], 1'b0};
      end
      if (t_im >= {1'b0, cur.den}) begin
        nxt.r_im = 32'(t_im - {1'b0, cur.den});
        nxt.q_im = {cur.q_im[NSTEP-2:0], 1'b1};
      end else begin
        nxt.r_im = t_im[31:0];
        nxt.q_im = {cur.q_im[NSTEP-2:0], 1'b0};
      end
      nxt.nb_re  = {cur.nb_re[NSTEP-2:0], 1'b0};
      nxt.nb_im  = {cur.nb_im[NSTEP-2:0], 1'b0};
      nxt.sq_s   = sq_s_n;
      nxt.sq_res = sq_res_n;
      nxt.cx     = cx_n;
      nxt.cy     = cy_n;
      nxt.cz     = cz_n;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vit_r[k+1] <= 1'b0;
      end else begin
        vit_r[k+1] <= vit_r[k];
      end
    end

    always_ff @(posedge clk) begin
      it_r[k+1] <= nxt;
    end
  end

  // ---------------- rounding stage ----------------
  iter_t              fin;
  logic               fa_v_r;
  cmd_t               fa_cmd_r;
  logic signed [16:0] fa_lre_r, fa_lim_r;
  logic signed [24:0] fa_mre_r, fa_mim_r;
  logic               fa_eq_r, fa_dz_r, fa_az_r;
  logic               fa_nre_r, fa_nim_r, fa_ovre_r, fa_ovim_r;
  logic [25:0]        fa_dre_r, fa_dim_r;
  logic [16:0]        fa_mag_r;
  logic [11:0]        fa_ang_r;
  logic signed [27:0] zc;

  assign fin = it_r[NSTEP];

  always_comb begin
    if (fin.cz < 28'sd0) begin
      zc = '0;
    end else if (fin.cz > ANG_PI) begin
      zc = ANG_PI;
    end else begin
      zc = fin.cz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_v_r <= 1'b0;
    end else begin
      fa_v_r <= vit_r[NSTEP];
    end
  end

  always_ff @(posedge clk) begin
    fa_cmd_r  <= fin.cmd;
    fa_lre_r  <= fin.lin_re;
    fa_lim_r  <= fin.lin_im;
    fa_mre_r  <= fin.mul_re;
    fa_mim_r  <= fin.mul_im;
    fa_eq_r   <= fin.eq;
    fa_dz_r   <= fin.den_zero;
    fa_az_r   <= fin.arg_zero;
    fa_nre_r  <= fin.neg_re;
    fa_nim_r  <= fin.neg_im;
    fa_ovre_r <= fin.ovf_re;
    fa_ovim_r <= fin.ovf_im;
    // round to nearest on the remainder: 2*rem >= den
    fa_dre_r  <= 26'(fin.q_re) + 26'({fin.r_re, 1'b0} >= {1'b0, fin.den});
    fa_dim_r  <= 26'(fin.q_im) + 26'({fin.r_im, 1'b0} >= {1'b0, fin.den});
    fa_mag_r  <= 17'(fin.sq_res + 32'(fin.sq_s > fin.sq_res));
    fa_ang_r  <= 12'((zc + 28'sd32768) >>> ANG_SH);
  end

  // ---------------- pack and output register ----------------
  logic                     out_valid_r;
  logic [DATA_W-1:0]        res_re_r, res_im_r, res_re_nxt, res_im_nxt;
  logic                     eq_r, eq_nxt;
  status_t                  st_r, st_nxt;
  sat_t                     s_re, s_im;

  always_comb begin
    res_re_nxt = '0;
    res_im_nxt = '0;
    eq_nxt     = 1'b0;
    st_nxt     = ST_OK;
    s_re       = '0;
    s_im       = '0;
    case (fa_cmd_r)
      CMD_ADD, CMD_SUB: begin
        s_re = sat_sv(26'(fa_lre_r));
        s_im = sat_sv(26'(fa_lim_r));
      end
      CMD_MUL: begin
        s_re = sat_sv(26'(fa_mre_r));
        s_im = sat_sv(26'(fa_mim_r));
      end
      CMD_DIV: begin
        if (!fa_dz_r) begin
          s_re = sat_sm(fa_nre_r, fa_dre_r, fa_ovre_r);
          s_im = sat_sm(fa_nim_r, fa_dim_r, fa_ovim_r);
        end
      end
      CMD_MAG: begin
        s_re = sat_sm(1'b0, 26'(fa_mag_r), 1'b0);
      end
      CMD_ARG: begin
        if (!fa_az_r) begin
          s_re.val = DATA_W'(fa_ang_r);
        end
      end
      CMD_EQ: begin
        eq_nxt = fa_eq_r;
      end
      default: begin
      end
    endcase
    res_re_nxt = s_re.val;
    res_im_nxt = s_im.val;
    if ((fa_cmd_r == CMD_DIV && fa_dz_r) || (fa_cmd_r == CMD_ARG && fa_az_r)) begin
      st_nxt = ST_UNDEF;
    end else if (fa_cmd_r > CMD_EQ) begin
      st_nxt = ST_UNDEF;
    end else if (s_re.sat || s_im.sat) begin
      st_nxt = ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fa_v_r;
    end
  end

  always_ff @(posedge clk) begin
    res_re_r <= res_re_nxt;
    res_im_r <= res_im_nxt;
    eq_r     <= eq_nxt;
    st_r     <= st_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_res_real = res_re_r;
  assign out_res_imag = res_im_r;
  assign out_is_equal = eq_r;
  assign out_status   = st_r;

  // ---------------- assertions ----------------
  `CAU_ASSERT_NOW(a_eq_clean, out_valid && out_is_equal, out_status == ST_OK && out_res_real == '0 && out_res_imag == '0, "equal result carries data or bad status")
  `CAU_ASSERT_NOW(a_undef_zero, out_valid && out_status == ST_UNDEF, out_res_real == '0 && out_res_imag == '0 && !out_is_equal, "undefined result is not zero")
  `CAU_ASSERT_NOW(a_ang_range, fa_v_r && fa_cmd_r == CMD_ARG, fa_ang_r <= ANG_Q_MAX, "angle beyond pi")
  `CAU_ASSERT_NEXT(a_flow, fa_v_r, out_valid, "rounding stage item lost before output")

endmodule
